// File: hw/rtl/triangle_coverage_rasterizer_defines.svh
// Assertion macros shared by the rasterizer RTL.
// Uses clk_i and rst_ni of the module that expands them.
`ifndef TRIANGLE_COVERAGE_RASTERIZER_DEFINES_SVH
`define TRIANGLE_COVERAGE_RASTERIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tcr assertion failed");
`define TCR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tcr forbidden condition");
`else
`define TCR_ASSERT(lbl, prop)
`define TCR_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/tcr_pkg.sv
// Shared types and constants of the triangle coverage rasterizer.
// No dependencies.
package tcr_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned RD_IDX_W  = 7;
  localparam int unsigned IDX_EXT_W = 12;
  localparam int unsigned MUL_STEPS = 6;
  localparam logic [2:0]  MUL_LAST  = 3'(MUL_STEPS - 1);
  localparam logic [WORD_W-1:0] HALF_WORD = 32'h3F00_0000;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_MUL,
    ST_DRAIN,
    ST_WALK,
    ST_RDWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic box_en;
    logic mul_en;
    logic walk_en;
    logic rd_en;
  } ctl_cmd_t;

  typedef struct packed {
    logic box_empty;
    logic mul_last;
    logic walk_last;
  } ctl_sts_t;

endpackage

// File: hw/rtl/tcr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tcr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tcr_ctrl.sv
// Sequencing state machine of the rasterizer.
// Depends on tcr_pkg.
module tcr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  tcr_pkg::op_e      op_i,
  input  tcr_pkg::ctl_sts_t sts_i,
  output tcr_pkg::ctl_cmd_t cmd_o,
  output logic              busy,
  output logic              done_o
);
  import tcr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (op_i)
            OP_CLEAR: state_d = ST_WALK;
            OP_DRAW:  state_d = ST_BOX;
            OP_READ:  state_d = ST_RDWAIT;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_BOX:    state_d = sts_i.box_empty ? ST_DONE : ST_MUL;
      ST_MUL:    state_d = sts_i.mul_last ? ST_DRAIN : ST_MUL;
      ST_DRAIN:  state_d = ST_WALK;
      ST_WALK:   state_d = sts_i.walk_last ? ST_DONE : ST_WALK;
      ST_RDWAIT: state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_BOX:    cmd_o.box_en  = 1'b1;
      ST_MUL:    cmd_o.mul_en  = 1'b1;
      ST_DRAIN:  ;
      ST_WALK:   cmd_o.walk_en = 1'b1;
      ST_RDWAIT: cmd_o.rd_en   = 1'b1;
      ST_DONE:   done_o        = 1'b1;
      default:   ;
    endcase
  end

endmodule

// File: hw/rtl/tcr_datapath.sv
// Datapath: bounding box, edge setup multiplier, box walker and texel buffer.
// Depends on tcr_pkg and tcr_ram.
module tcr_datapath #(
  parameter int unsigned BUF_WIDTH  = 128,
  parameter int unsigned BUF_HEIGHT = 128,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcr_pkg::ctl_cmd_t              cmd_i,
  output tcr_pkg::ctl_sts_t              sts_o,
  input  logic [1:0]                     operation_i,
  input  logic signed [COORD_BITS-1:0]   first_x_i,
  input  logic signed [COORD_BITS-1:0]   first_y_i,
  input  logic signed [COORD_BITS-1:0]   second_x_i,
  input  logic signed [COORD_BITS-1:0]   second_y_i,
  input  logic signed [COORD_BITS-1:0]   third_x_i,
  input  logic signed [COORD_BITS-1:0]   third_y_i,
  input  logic [tcr_pkg::WORD_W-1:0]     fill_word_i,
  input  logic [tcr_pkg::RD_IDX_W-1:0]   read_col_i,
  input  logic [tcr_pkg::RD_IDX_W-1:0]   read_row_i,
  output logic [tcr_pkg::WORD_W-1:0]     texel_word_o,
  output logic [1:0]                     finished_op_o
);
  import tcr_pkg::*;

  localparam int unsigned XW  = $clog2(BUF_WIDTH);
  localparam int unsigned YW  = $clog2(BUF_HEIGHT);
  localparam int unsigned MW  = (XW > YW) ? XW : YW;
  localparam int unsigned SW  = ((COORD_BITS > MW) ? COORD_BITS : MW) + 1;
  localparam int unsigned DW  = SW + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned EW  = PW + 1;
  localparam int unsigned AW  = XW + YW;
  localparam logic signed [SW-1:0] XMAX = SW'(BUF_WIDTH - 1);
  localparam logic signed [SW-1:0] YMAX = SW'(BUF_HEIGHT - 1);
  localparam logic [1:0] EDGE_A [3] = '{2'd1, 2'd2, 2'd0};
  localparam logic [1:0] EDGE_B [3] = '{2'd2, 2'd0, 2'd1};

  op_e                         op_q;
  logic signed [COORD_BITS-1:0] vx_q [3];
  logic signed [COORD_BITS-1:0] vy_q [3];
  logic [WORD_W-1:0]           fill_q;
  logic [RD_IDX_W-1:0]         col_q, row_q;

  logic signed [SW-1:0] sx [3];
  logic signed [SW-1:0] sy [3];
  logic signed [SW-1:0] xmin, xmax, ymin, ymax, lox_c, hix_c, loy_c, hiy_c;

  logic [XW-1:0] lox_q, hix_q, x_q;
  logic [YW-1:0] loy_q, hiy_q, y_q;

  logic signed [DW-1:0] ex_q [3];
  logic signed [DW-1:0] ey_q [3];
  logic signed [EW-1:0] e_q [3];
  logic signed [EW-1:0] erow_q [3];

  logic [2:0]           mul_idx_q, pidx_q;
  logic                 pvld_q;
  logic [1:0]           mk, ak;
  logic signed [DW-1:0] opa, opb;
  logic signed [PW-1:0] prod_d, prod_q;

  logic                 covered, walk_last, rd_ok, we;
  logic [WORD_W-1:0]    wdata, rdata;
  logic [IDX_EXT_W-1:0] col_ext, row_ext;

  // bounding box
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sx[i] = SW'(vx_q[i]);
      sy[i] = SW'(vy_q[i]);
    end
    xmin = sx[0];
    xmax = sx[0];
    ymin = sy[0];
    ymax = sy[0];
    for (int i = 1; i < 3; i++) begin
      if (sx[i] < xmin) xmin = sx[i];
      if (sx[i] > xmax) xmax = sx[i];
      if (sy[i] < ymin) ymin = sy[i];
      if (sy[i] > ymax) ymax = sy[i];
    end
    lox_c = (xmin < 0) ? '0 : xmin;
    hix_c = (xmax > XMAX) ? XMAX : xmax;
    loy_c = (ymin < 0) ? '0 : ymin;
    hiy_c = (ymax > YMAX) ? YMAX : ymax;
  end

  // setup multiplier operands
  always_comb begin
    mk = mul_idx_q[2:1];
    unique case (mk)
      2'd0:    ak = EDGE_A[0];
      2'd1:    ak = EDGE_A[1];
      default: ak = EDGE_A[2];
    endcase
    if (!mul_idx_q[0]) begin
      opa = ey_q[ak == EDGE_A[0] ? 0 : (ak == EDGE_A[1] ? 1 : 2)];
      opb = DW'($signed({1'b0, loy_q})) - DW'(sy[ak]);
    end else begin
      opa = ex_q[ak == EDGE_A[0] ? 0 : (ak == EDGE_A[1] ? 1 : 2)];
      opb = DW'($signed({1'b0, lox_q})) - DW'(sx[ak]);
    end
    prod_d = PW'(opa) * PW'(opb);
  end

  always_comb begin
    covered = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (e_q[k][EW-1]) covered = 1'b0;
    end
  end

  assign walk_last = (x_q == hix_q) && (y_q == hiy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_idx_q <= '0;
      pvld_q    <= 1'b0;
      op_q      <= OP_NONE;
    end else begin
      pvld_q <= cmd_i.mul_en;
      if (cmd_i.load) begin
        op_q <= op_e'(operation_i);
      end
      if (cmd_i.box_en) begin
        mul_idx_q <= '0;
      end else if (cmd_i.mul_en) begin
        mul_idx_q <= mul_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vx_q[0] <= first_x_i;
      vy_q[0] <= first_y_i;
      vx_q[1] <= second_x_i;
      vy_q[1] <= second_y_i;
      vx_q[2] <= third_x_i;
      vy_q[2] <= third_y_i;
      fill_q  <= fill_word_i;
      col_q   <= read_col_i;
      row_q   <= read_row_i;
      lox_q   <= '0;
      hix_q   <= XW'(BUF_WIDTH - 1);
      loy_q   <= '0;
      hiy_q   <= YW'(BUF_HEIGHT - 1);
      x_q     <= '0;
      y_q     <= '0;
    end
    if (cmd_i.box_en) begin
      lox_q <= lox_c[XW-1:0];
      hix_q <= hix_c[XW-1:0];
      loy_q <= loy_c[YW-1:0];
      hiy_q <= hiy_c[YW-1:0];
      x_q   <= lox_c[XW-1:0];
      y_q   <= loy_c[YW-1:0];
      for (int k = 0; k < 3; k++) begin
        ey_q[k] <= DW'(sx[EDGE_B[k]]) - DW'(sx[EDGE_A[k]]);
        ex_q[k] <= DW'(sy[EDGE_B[k]]) - DW'(sy[EDGE_A[k]]);
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      pidx_q <= mul_idx_q;
    end
    if (pvld_q) begin
      for (int k = 0; k < 3; k++) begin
        if (pidx_q[2:1] == 2'(k)) begin
          if (!pidx_q[0]) begin
            e_q[k]    <= EW'(prod_q);
            erow_q[k] <= EW'(prod_q);
          end else begin
            e_q[k]    <= e_q[k] - EW'(prod_q);
            erow_q[k] <= e_q[k] - EW'(prod_q);
          end
        end
      end
    end
    if (cmd_i.walk_en) begin
      if (x_q == hix_q) begin
        x_q <= lox_q;
        y_q <= y_q + YW'(1);
        for (int k = 0; k < 3; k++) begin
          e_q[k]    <= erow_q[k] + EW'(ey_q[k]);
          erow_q[k] <= erow_q[k] + EW'(ey_q[k]);
        end
      end else begin
        x_q <= x_q + XW'(1);
        for (int k = 0; k < 3; k++) begin
          e_q[k] <= e_q[k] - EW'(ex_q[k]);
        end
      end
    end
  end

  assign we      = cmd_i.walk_en && ((op_q == OP_CLEAR) || covered);
  assign wdata   = (op_q == OP_CLEAR) ? fill_q : HALF_WORD;
  assign col_ext = IDX_EXT_W'(col_q);
  assign row_ext = IDX_EXT_W'(row_q);
  assign rd_ok   = (col_ext < IDX_EXT_W'(BUF_WIDTH)) && (row_ext < IDX_EXT_W'(BUF_HEIGHT));

  tcr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({y_q, x_q}),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i ({row_ext[YW-1:0], col_ext[XW-1:0]}),
    .rdata_o (rdata)
  );

  assign sts_o.box_empty = (xmax < 0) || (xmin > XMAX) || (ymax < 0) || (ymin > YMAX);
  assign sts_o.mul_last  = (mul_idx_q == MUL_LAST);
  assign sts_o.walk_last = walk_last;

  assign texel_word_o  = ((op_q == OP_READ) && rd_ok) ? rdata : '0;
  assign finished_op_o = op_q;

endmodule

// File: hw/rtl/triangle_coverage_rasterizer.sv
// Operations: clear, draw, read and an unused code that only reports done;
// done_o pulses in the last cycle, busy is high meanwhile.
// The walker steps one texel per cycle; the six setup products share one multiplier.
// A new item is taken the cycle after done_o; results cannot be stalled.
// Reset clears control only; the texel buffer holds nothing valid until a clear.
`include "triangle_coverage_rasterizer_defines.svh"
module triangle_coverage_rasterizer #(
  parameter int unsigned BUF_WIDTH  = 128,
  parameter int unsigned BUF_HEIGHT = 128,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation_i,
  input  logic signed [COORD_BITS-1:0] first_x_i,
  input  logic signed [COORD_BITS-1:0] first_y_i,
  input  logic signed [COORD_BITS-1:0] second_x_i,
  input  logic signed [COORD_BITS-1:0] second_y_i,
  input  logic signed [COORD_BITS-1:0] third_x_i,
  input  logic signed [COORD_BITS-1:0] third_y_i,
  input  logic [tcr_pkg::WORD_W-1:0]   fill_word_i,
  input  logic [tcr_pkg::RD_IDX_W-1:0] read_col_i,
  input  logic [tcr_pkg::RD_IDX_W-1:0] read_row_i,
  output logic                         done_o,
  output logic [tcr_pkg::WORD_W-1:0]   texel_word_o,
  output logic [1:0]                   finished_op_o
);
  import tcr_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  tcr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_e'(operation_i)),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  tcr_datapath #(
    .BUF_WIDTH  (BUF_WIDTH),
    .BUF_HEIGHT (BUF_HEIGHT),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .first_x_i     (first_x_i),
    .first_y_i     (first_y_i),
    .second_x_i    (second_x_i),
    .second_y_i    (second_y_i),
    .third_x_i     (third_x_i),
    .third_y_i     (third_y_i),
    .fill_word_i   (fill_word_i),
    .read_col_i    (read_col_i),
    .read_row_i    (read_row_i),
    .texel_word_o  (texel_word_o),
    .finished_op_o (finished_op_o)
  );

  `TCR_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `TCR_ASSERT(a_done_frees, done_o |=> !busy)
  `TCR_ASSERT(a_done_in_busy, done_o |-> busy)
  `TCR_ASSERT_NEVER(a_zero_non_read, done_o && (finished_op_o != OP_READ) && (texel_word_o != '0))

endmodule

// File: dv/triangle_coverage_rasterizer_tb.sv
// Testbench for triangle_coverage_rasterizer: directed and random clear/draw/read transfers,
// with results checked against a scoreboard that keeps its own copy of the texel buffer.
// Depends on tcr_pkg and the rasterizer RTL only.
module triangle_coverage_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcr_pkg::*;

  localparam int BUF_W      = 128;
  localparam int BUF_H      = 128;
  localparam int COORD_W    = 12;
  localparam int TEXELS     = BUF_W * BUF_H;
  localparam int NUM_RANDOM = 1725;
  localparam int PHASE_LEN  = 120;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    op_e                 op;
    coord_t              first_x, first_y, second_x, second_y, third_x, third_y;
    logic [WORD_W-1:0]   fill_word;
    logic [RD_IDX_W-1:0] read_col, read_row;
  } raster_cmd_t;

  typedef struct {
    logic [WORD_W-1:0] texel_word;
    logic [1:0]        finished_op;
  } raster_result_t;

  class texel_scoreboard;
    logic [WORD_W-1:0] texel_mem [TEXELS];
    raster_result_t    pending_results [$];
    int unsigned       mismatches;
    int unsigned       last_cycles;

    function longint edge_value(longint ax, longint ay, longint bx, longint by,
                                longint px, longint py);
      return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    function void draw_triangle(longint x0, longint y0, longint x1, longint y1,
                                longint x2, longint y2);
      longint      lox, hix, loy, hiy, px, py;
      int unsigned visited;
      lox = (x0 < x1) ? x0 : x1;
      lox = (lox < x2) ? lox : x2;
      hix = (x0 > x1) ? x0 : x1;
      hix = (hix > x2) ? hix : x2;
      loy = (y0 < y1) ? y0 : y1;
      loy = (loy < y2) ? loy : y2;
      hiy = (y0 > y1) ? y0 : y1;
      hiy = (hiy > y2) ? hiy : y2;
      if (lox < 0) lox = 0;
      if (loy < 0) loy = 0;
      if (hix > BUF_W - 1) hix = BUF_W - 1;
      if (hiy > BUF_H - 1) hiy = BUF_H - 1;
      visited = 0;
      for (py = loy; py <= hiy; py++) begin
        for (px = lox; px <= hix; px++) begin
          visited++;
          if (edge_value(x1, y1, x2, y2, px, py) >= 0 &&
              edge_value(x2, y2, x0, y0, px, py) >= 0 &&
              edge_value(x0, y0, x1, y1, px, py) >= 0) begin
            texel_mem[px + py * BUF_W] = HALF_WORD;
          end
        end
      end
      last_cycles = (visited == 0) ? 2 : 9 + visited;
    endfunction

    // accepted input transfer: update the buffer copy and queue the result it causes
    function void note_transfer(raster_cmd_t c);
      raster_result_t r;
      r.texel_word  = '0;
      r.finished_op = c.op;
      case (c.op)
        OP_CLEAR: begin
          foreach (texel_mem[i]) texel_mem[i] = c.fill_word;
          last_cycles = TEXELS + 1;
        end
        OP_DRAW: begin
          draw_triangle(c.first_x, c.first_y, c.second_x, c.second_y,
                        c.third_x, c.third_y);
        end
        OP_READ: begin
          if (c.read_col < BUF_W && c.read_row < BUF_H) begin
            r.texel_word = texel_mem[int'(c.read_col) + int'(c.read_row) * BUF_W];
          end
          last_cycles = 2;
        end
        default: last_cycles = 1;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_transfer(logic [WORD_W-1:0] word, logic [1:0] op);
      raster_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result texel_word %h finished_op %0d", $time, word, op);
        return;
      end
      want = pending_results.pop_front();
      if (word !== want.texel_word) begin
        mismatches++;
        $display("%0t: texel_word expected %h actual %h", $time, want.texel_word, word);
      end
      if (op !== want.finished_op) begin
        mismatches++;
        $display("%0t: finished_op expected %0d actual %0d", $time, want.finished_op, op);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          operation_i;
  coord_t              first_x_i, first_y_i, second_x_i, second_y_i, third_x_i, third_y_i;
  logic [WORD_W-1:0]   fill_word_i;
  logic [RD_IDX_W-1:0] read_col_i, read_row_i;
  logic                done_o;
  logic [WORD_W-1:0]   texel_word_o;
  logic [1:0]          finished_op_o;

  texel_scoreboard sb = new();
  longint          budget = 0;
  longint          cycle_count = 0;
  int              anchor_x = 0;
  int              anchor_y = 0;
  int              phase_idle [3] = '{0, 75, 35};

  triangle_coverage_rasterizer #(
    .BUF_WIDTH (BUF_W),
    .BUF_HEIGHT(BUF_H),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .third_x_i    (third_x_i),
    .third_y_i    (third_y_i),
    .fill_word_i  (fill_word_i),
    .read_col_i   (read_col_i),
    .read_row_i   (read_row_i),
    .done_o       (done_o),
    .texel_word_o (texel_word_o),
    .finished_op_o(finished_op_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int clamp_idx(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  function automatic raster_cmd_t noise_cmd(op_e op);
    raster_cmd_t c;
    c.op        = op;
    c.first_x   = coord_t'($urandom());
    c.first_y   = coord_t'($urandom());
    c.second_x  = coord_t'($urandom());
    c.second_y  = coord_t'($urandom());
    c.third_x   = coord_t'($urandom());
    c.third_y   = coord_t'($urandom());
    c.fill_word = $urandom();
    c.read_col  = RD_IDX_W'($urandom());
    c.read_row  = RD_IDX_W'($urandom());
    return c;
  endfunction

  function automatic raster_cmd_t clear_cmd(logic [WORD_W-1:0] word);
    raster_cmd_t c;
    c = noise_cmd(OP_CLEAR);
    c.fill_word = word;
    return c;
  endfunction

  function automatic raster_cmd_t draw_cmd(int ax, int ay, int bx, int by, int cx, int cy);
    raster_cmd_t c;
    c = noise_cmd(OP_DRAW);
    c.first_x  = coord_t'(ax);
    c.first_y  = coord_t'(ay);
    c.second_x = coord_t'(bx);
    c.second_y = coord_t'(by);
    c.third_x  = coord_t'(cx);
    c.third_y  = coord_t'(cy);
    anchor_x = clamp_idx(c.first_x, BUF_W - 1);
    anchor_y = clamp_idx(c.first_y, BUF_H - 1);
    return c;
  endfunction

  function automatic raster_cmd_t read_cmd(int col, int row);
    raster_cmd_t c;
    c = noise_cmd(OP_READ);
    c.read_col = RD_IDX_W'(col);
    c.read_row = RD_IDX_W'(row);
    return c;
  endfunction

  function automatic raster_cmd_t random_cmd();
    int pick, kind, bx, by, dx, dy;
    pick = $urandom_range(999);
    if (pick < 4) return clear_cmd($urandom());
    if (pick < 14) return noise_cmd(OP_NONE);
    if (pick < 520) begin
      kind = $urandom_range(99);
      if (kind < 3) return draw_cmd($urandom(), $urandom(), $urandom(), $urandom(),
                                    $urandom(), $urandom());
      if (kind < 10) begin
        // vertices offset from a random base point by random multiples of dx and dy
        bx = $urandom_range(BUF_W - 1);
        by = $urandom_range(BUF_H - 1);
        dx = int'($urandom_range(8)) - 4;
        dy = int'($urandom_range(8)) - 4;
        return draw_cmd(bx, by,
                        bx + dx * (int'($urandom_range(8)) - 4),
                        by + dy * (int'($urandom_range(8)) - 4),
                        bx + dx * (int'($urandom_range(8)) - 4),
                        by + dy * (int'($urandom_range(8)) - 4));
      end
      if (kind < 14) begin
        if ($urandom_range(1)) begin
          return draw_cmd(-int'($urandom_range(2048, 1)), $urandom(),
                          -int'($urandom_range(2048, 1)), $urandom(),
                          -int'($urandom_range(2048, 1)), $urandom());
        end
        return draw_cmd($urandom(), $urandom_range(2047, BUF_H),
                        $urandom(), $urandom_range(2047, BUF_H),
                        $urandom(), $urandom_range(2047, BUF_H));
      end
      bx = int'($urandom_range(BUF_W + 39)) - 20;
      by = int'($urandom_range(BUF_H + 39)) - 20;
      return draw_cmd(bx + int'($urandom_range(30)) - 15, by + int'($urandom_range(30)) - 15,
                      bx + int'($urandom_range(30)) - 15, by + int'($urandom_range(30)) - 15,
                      bx + int'($urandom_range(30)) - 15, by + int'($urandom_range(30)) - 15);
    end
    if ($urandom_range(9) < 6) begin
      return read_cmd(clamp_idx(anchor_x + int'($urandom_range(16)) - 8, BUF_W - 1),
                      clamp_idx(anchor_y + int'($urandom_range(16)) - 8, BUF_H - 1));
    end
    return read_cmd($urandom_range(BUF_W - 1), $urandom_range(BUF_H - 1));
  endfunction

  // holds the transfer until the edge where start is high and busy is low
  task automatic send_cmd(raster_cmd_t c);
    start       <= 1'b1;
    operation_i <= c.op;
    first_x_i   <= c.first_x;
    first_y_i   <= c.first_y;
    second_x_i  <= c.second_x;
    second_y_i  <= c.second_y;
    third_x_i   <= c.third_x;
    third_y_i   <= c.third_y;
    fill_word_i <= c.fill_word;
    read_col_i  <= c.read_col;
    read_row_i  <= c.read_row;
    do @(posedge clk_i); while (busy);
    sb.note_transfer(c);
    budget += sb.last_cycles + 100;
  endtask

  task automatic idle_gap(int pct);
    while (int'($urandom_range(99)) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_transfer(texel_word_o, finished_op_o);
  end

  initial begin
    while (cycle_count <= 4 * budget + 50000) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    operation_i = OP_NONE;
    first_x_i   = '0;
    first_y_i   = '0;
    second_x_i  = '0;
    second_y_i  = '0;
    third_x_i   = '0;
    third_y_i   = '0;
    fill_word_i = '0;
    read_col_i  = '0;
    read_row_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // draw before any clear; only covered texels are read back
    send_cmd(draw_cmd(0, 0, 6, 0, 0, 6));
    send_cmd(read_cmd(0, 0));
    send_cmd(read_cmd(3, 3));
    send_cmd(clear_cmd(32'hFFFF_FFFF));
    send_cmd(read_cmd(BUF_W - 1, 0));
    send_cmd(clear_cmd(32'h0000_0000));
    send_cmd(read_cmd(0, BUF_H - 1));
    send_cmd(clear_cmd(32'hA5A5_5A5A));
    // extreme vertices, both windings
    send_cmd(draw_cmd(-2048, -2048, 2047, -2048, -2048, 2047));
    send_cmd(draw_cmd(-2048, -2048, -2048, 2047, 2047, -2048));
    send_cmd(read_cmd(BUF_W / 2, BUF_H / 2));
    send_cmd(draw_cmd(-2048, -2048, 2047, 2047, 2047, -2048));
    send_cmd(draw_cmd(-2048, -2048, 2047, -2048, 2047, 2047));
    send_cmd(read_cmd(BUF_W - 1, BUF_H - 1));
    // boxes that miss the buffer
    send_cmd(draw_cmd(-100, -5, -2, -50, -30, -1));
    send_cmd(draw_cmd(200, 10, 300, 20, 2047, 100));
    // degenerate: a line and a single point
    send_cmd(draw_cmd(10, 10, 20, 20, 30, 30));
    send_cmd(read_cmd(15, 15));
    send_cmd(draw_cmd(40, 50, 40, 50, 40, 50));
    send_cmd(read_cmd(40, 50));
    send_cmd(noise_cmd(OP_NONE));
    send_cmd(read_cmd(0, 0));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      idle_gap(phase_idle[(n / PHASE_LEN) % 3]);
      send_cmd(random_cmd());
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
